[sv/union_find_table_defines.svh]
// Assertion macros shared by the union-find table checker
`ifndef UNION_FIND_TABLE_DEFINES_SVH
`define UNION_FIND_TABLE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define UFT_ASSERT_NOW(label, clk_s, rst_ns, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
		else $error("union_find_table: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted
`define UFT_ASSERT_NEXT(label, clk_s, rst_ns, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
		else $error("union_find_table: next-cycle check failed");

`endif

[sv/uft_pkg.sv]
// Shared types and constants of the union-find table
`timescale 1ns / 1ps

package uft_pkg;

	localparam int IDX_W = 10;
	localparam int CNT_W = 11;

	localparam logic [CNT_W-1:0] ECOUNT_RESET = 11'd1024;
	localparam logic [CNT_W-1:0] MERGE_MAX    = 11'h7FF;

	localparam logic [1:0] KIND_FIND  = 2'd0;
	localparam logic [1:0] KIND_MERGE = 2'd1;

	typedef enum logic [1:0] {
		WALK_IDLE,
		WALK_UP,
		WALK_CPRS,
		WALK_DONE
	} walk_state_t;

	typedef enum logic [2:0] {
		CTL_CLEAR,
		CTL_IDLE,
		CTL_FIND_A,
		CTL_FIND_B,
		CTL_JOIN_A,
		CTL_JOIN_B,
		CTL_OUT
	} ctl_state_t;

endpackage

[sv/uft_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module uft_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/uft_walk.sv]
// Find engine: walk parent links to the root, then compress the path
`timescale 1ns / 1ps

module uft_walk #(
	parameter int ADDR_W = 10,
	parameter int ENT_W  = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ADDR_W-1:0] start_idx,
	input  logic [ENT_W-1:0]  rdata,
	output logic [ADDR_W-1:0] raddr,
	output logic              we,
	output logic [ADDR_W-1:0] waddr,
	output logic [ENT_W-1:0]  wdata,
	output logic              done,
	output logic [ADDR_W-1:0] root,
	output logic [ENT_W-1:0]  root_val
);

	import uft_pkg::*;

	walk_state_t       state_q, state_nxt;
	logic [ADDR_W-1:0] start_q, cur_q, root_q;
	logic [ENT_W-1:0]  rval_q;
	logic              ent_neg;
	logic [ADDR_W-1:0] nxt_idx;

	assign ent_neg = rdata[ENT_W-1];
	assign nxt_idx = rdata[ADDR_W-1:0];

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			WALK_IDLE, WALK_DONE: begin
				state_nxt = start ? WALK_UP : WALK_IDLE;
			end
			WALK_UP: begin
				if (ent_neg) begin
					state_nxt = (cur_q == start_q) ? WALK_DONE : WALK_CPRS;
				end
			end
			WALK_CPRS: begin
				if (nxt_idx == root_q) begin
					state_nxt = WALK_DONE;
				end
			end
			default: state_nxt = WALK_IDLE;
		endcase
	end

	always_comb begin
		raddr = start_idx;
		we    = 1'b0;
		waddr = cur_q;
		wdata = {1'b0, root_q};
		done  = 1'b0;
		case (state_q)
			WALK_IDLE: raddr = start_idx;
			WALK_DONE: begin
				raddr = start_idx;
				done  = 1'b1;
			end
			WALK_UP: raddr = ent_neg ? start_q : nxt_idx;
			WALK_CPRS: begin
				raddr = nxt_idx;
				we    = 1'b1;
			end
			default: raddr = start_idx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WALK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			WALK_IDLE, WALK_DONE: begin
				if (start) begin
					start_q <= start_idx;
					cur_q   <= start_idx;
				end
			end
			WALK_UP: begin
				if (ent_neg) begin
					root_q <= cur_q;
					rval_q <= rdata;
					cur_q  <= start_q;
				end else begin
					cur_q <= nxt_idx;
				end
			end
			WALK_CPRS: cur_q <= nxt_idx;
			default: cur_q <= cur_q;
		endcase
	end

	assign root     = root_q;
	assign root_val = rval_q;

endmodule

[sv/union_find_table.sv]
// Union-find table top level: request sequencer, parent memory and find engine
`timescale 1ns / 1ps
// Items are handled one at a time: an item with an index error goes straight to the output
// register; a find walks from the first index up to its root, merge and query also walk from
// the second index, and a merge that joins two sets then writes both roots before the output.
// The single read port of the parent memory, walked one link a cycle, sets the pace of each walk.
// Reset: after arst_n releases, a clearing pass over all MAX_ELEMENTS entries marks every entry
// as a singleton root; no item is taken meanwhile, configuration writes are.

module union_find_table #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [uft_pkg::CNT_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  kind,
	input  logic [uft_pkg::IDX_W-1:0]   first_index,
	input  logic [uft_pkg::IDX_W-1:0]   second_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [uft_pkg::IDX_W-1:0]   first_root,
	output logic [uft_pkg::IDX_W-1:0]   second_root,
	output logic                        outcome_flag,
	output logic [uft_pkg::CNT_W-1:0]   set_size,
	output logic [uft_pkg::CNT_W-1:0]   component_count,
	output logic                        index_error
);

	import uft_pkg::*;

	// Entry: non-negative is the parent index, negative is minus the set size
	localparam int ADDR_W = $clog2(MAX_ELEMENTS);
	localparam int ENT_W  = ADDR_W + 1;

	ctl_state_t        state_q, state_nxt;

	// Configuration and long-lived state
	logic [CNT_W-1:0]  ecount_q;
	logic [CNT_W-1:0]  mcount_q;
	logic [ADDR_W-1:0] clr_q;

	// Request context
	logic [1:0]        kind_q;
	logic [ADDR_W-1:0] b_q;
	logic              err_q;
	logic              flag_q;
	logic [ADDR_W-1:0] ra_q, rb_q;
	logic [ENT_W-1:0]  va_q;

	// Output register
	logic              out_valid_q;
	logic [IDX_W-1:0]  first_root_q, second_root_q;
	logic              flag_out_q, err_out_q;
	logic [CNT_W-1:0]  size_out_q, comp_out_q;

	logic [CNT_W-1:0]  active_cnt;
	logic              in_err;
	logic              accept;
	logic              clr_last;
	logic              out_load;
	logic              is_merge;
	logic [ENT_W-1:0]  join_sum;
	logic [ENT_W-1:0]  size_neg;
	logic [CNT_W-1:0]  comp_now;

	// Find engine and memory wiring
	logic              walk_start;
	logic [ADDR_W-1:0] walk_idx;
	logic              walk_done;
	logic [ADDR_W-1:0] walk_root;
	logic [ENT_W-1:0]  walk_rval;
	logic [ADDR_W-1:0] walk_raddr, walk_waddr;
	logic              walk_we;
	logic [ENT_W-1:0]  walk_wdata;
	logic [ENT_W-1:0]  mem_rdata;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ENT_W-1:0]  mem_wdata;

	// Clamp the configured count to the table depth
	assign active_cnt = (32'(ecount_q) > MAX_ELEMENTS) ? CNT_W'(MAX_ELEMENTS) : ecount_q;
	assign in_err     = ({1'b0, first_index} >= active_cnt)
	                 || ((kind != KIND_FIND) && ({1'b0, second_index} >= active_cnt));
	assign accept     = in_valid && in_ready;
	assign clr_last   = (clr_q == ADDR_W'(MAX_ELEMENTS - 1));
	assign out_load   = (state_q == CTL_OUT) && (!out_valid_q || out_ready);
	assign is_merge   = (kind_q == KIND_MERGE);
	assign join_sum   = va_q + walk_rval;
	assign size_neg   = -va_q;
	assign comp_now   = (active_cnt > mcount_q) ? (active_cnt - mcount_q) : '0;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CTL_CLEAR: begin
				if (clr_last) begin
					state_nxt = CTL_IDLE;
				end
			end
			CTL_IDLE: begin
				if (in_valid) begin
					state_nxt = in_err ? CTL_OUT : CTL_FIND_A;
				end
			end
			CTL_FIND_A: begin
				if (walk_done) begin
					state_nxt = (kind_q == KIND_FIND) ? CTL_OUT : CTL_FIND_B;
				end
			end
			CTL_FIND_B: begin
				if (walk_done) begin
					state_nxt = (is_merge && (walk_root != ra_q)) ? CTL_JOIN_A : CTL_OUT;
				end
			end
			CTL_JOIN_A: state_nxt = CTL_JOIN_B;
			CTL_JOIN_B: state_nxt = CTL_OUT;
			CTL_OUT: begin
				if (out_load) begin
					state_nxt = CTL_IDLE;
				end
			end
			default: state_nxt = CTL_CLEAR;
		endcase
	end

	// Control outputs: handshake, engine launch, memory write mux
	always_comb begin
		in_ready   = 1'b0;
		walk_start = 1'b0;
		walk_idx   = b_q;
		mem_we     = 1'b0;
		mem_waddr  = walk_waddr;
		mem_wdata  = walk_wdata;
		case (state_q)
			CTL_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '1;
			end
			CTL_IDLE: begin
				in_ready   = 1'b1;
				walk_start = in_valid && !in_err;
				walk_idx   = ADDR_W'(first_index);
			end
			CTL_FIND_A: begin
				walk_start = walk_done && (kind_q != KIND_FIND);
				mem_we     = walk_we;
			end
			CTL_FIND_B: mem_we = walk_we;
			CTL_JOIN_A: begin
				// root of the first element takes the combined negative size
				mem_we    = 1'b1;
				mem_waddr = ra_q;
				mem_wdata = join_sum;
			end
			CTL_JOIN_B: begin
				// hang the second root under the first
				mem_we    = 1'b1;
				mem_waddr = rb_q;
				mem_wdata = {1'b0, ra_q};
			end
			CTL_OUT: mem_we = 1'b0;
			default: mem_we = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_CLEAR;
			ecount_q    <= ECOUNT_RESET;
			mcount_q    <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				ecount_q <= cfg_wr_data;
			end
			if (state_q == CTL_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			// a join counts once; hold at the top of the range
			if ((state_q == CTL_JOIN_B) && (mcount_q != MERGE_MAX)) begin
				mcount_q <= mcount_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request context and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			b_q    <= ADDR_W'(second_index);
			err_q  <= in_err;
			flag_q <= 1'b0;
			ra_q   <= '0;
			rb_q   <= '0;
			va_q   <= '0;
		end
		if ((state_q == CTL_FIND_A) && walk_done) begin
			ra_q <= walk_root;
			va_q <= walk_rval;
		end
		if ((state_q == CTL_FIND_B) && walk_done) begin
			rb_q   <= walk_root;
			flag_q <= is_merge ? (walk_root != ra_q) : (walk_root == ra_q);
		end
		if (state_q == CTL_JOIN_A) begin
			va_q <= join_sum;
		end
		if (state_q == CTL_JOIN_B) begin
			rb_q <= ra_q;
		end
		if (out_load) begin
			first_root_q  <= IDX_W'(ra_q);
			second_root_q <= IDX_W'(rb_q);
			flag_out_q    <= flag_q;
			size_out_q    <= CNT_W'(size_neg);
			comp_out_q    <= comp_now;
			err_out_q     <= err_q;
		end
	end

	uft_walk #(
		.ADDR_W (ADDR_W),
		.ENT_W  (ENT_W)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (walk_start),
		.start_idx (walk_idx),
		.rdata     (mem_rdata),
		.raddr     (walk_raddr),
		.we        (walk_we),
		.waddr     (walk_waddr),
		.wdata     (walk_wdata),
		.done      (walk_done),
		.root      (walk_root),
		.root_val  (walk_rval)
	);

	uft_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_ELEMENTS)
	) u_parent_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (walk_raddr),
		.rdata (mem_rdata)
	);

	assign out_valid       = out_valid_q;
	assign first_root      = first_root_q;
	assign second_root     = second_root_q;
	assign outcome_flag    = flag_out_q;
	assign set_size        = size_out_q;
	assign component_count = comp_out_q;
	assign index_error     = err_out_q;

endmodule

[sv/uft_checker.sv]
// Port-level checker for the union-find table, bound to the top level
`timescale 1ns / 1ps
`include "union_find_table_defines.svh"

module uft_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [uft_pkg::IDX_W-1:0] first_root,
	input logic [uft_pkg::IDX_W-1:0] second_root,
	input logic                      outcome_flag,
	input logic [uft_pkg::CNT_W-1:0] set_size,
	input logic                      index_error
);

	logic                                     out_stall;
	logic                                     in_xfer;
	logic                                     err_out;
	logic                                     err_zero;
	logic [uft_pkg::IDX_W+uft_pkg::CNT_W-1:0] shown;

	assign out_stall = out_valid && !out_ready;
	assign in_xfer   = in_valid && in_ready;
	assign err_out   = out_valid && index_error;
	assign err_zero  = (first_root == '0) && (second_root == '0) && !outcome_flag
	                && (set_size == '0);
	assign shown     = {first_root, set_size};

	// a stalled result stays offered
	`UFT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(shown))
	// one item in flight: a transfer in closes the input side for the next cycle
	`UFT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_xfer, !in_ready)
	// a rejected index leaves both roots, the outcome flag and the set size at zero
	`UFT_ASSERT_NOW(a_err_zero, clk, arst_n, err_out, err_zero)
	// a valid find, merge or query always names a non-empty set
	`UFT_ASSERT_NOW(a_size_nonzero, clk, arst_n, out_valid && !index_error, set_size != '0)

endmodule

bind union_find_table uft_checker u_uft_checker (.*);
